// ===== sv/clt_pkg.sv =====
package clt_pkg;

    // default geometry
    localparam int DEF_COLUMNS    = 16;
    localparam int DEF_ROWS       = 2;
    localparam int DEF_TAB_SPACES = 8;

    // fixed field widths
    localparam int COL_W  = 5;
    localparam int TAB_W  = 3;
    localparam int SLOT_W = 4;

    localparam logic [SLOT_W-1:0] SLOT_LAST = 4'd15;

    // character codes
    localparam logic [7:0] CHAR_BS     = 8'd8;
    localparam logic [7:0] CHAR_TAB    = 8'd9;
    localparam logic [7:0] CHAR_LF     = 8'd10;
    localparam logic [7:0] CHAR_CR     = 8'd13;
    localparam logic [7:0] CHAR_ESC    = 8'd27;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_SEMI   = 8'h3B;
    localparam logic [7:0] CHAR_A      = 8'h41;
    localparam logic [7:0] CHAR_B      = 8'h42;
    localparam logic [7:0] CHAR_C      = 8'h43;
    localparam logic [7:0] CHAR_D      = 8'h44;
    localparam logic [7:0] CHAR_H      = 8'h48;
    localparam logic [7:0] CHAR_J      = 8'h4A;
    localparam logic [7:0] CHAR_LBRACK = 8'h5B;

    // controller commands
    localparam logic [7:0] CMD_BLANK_ALL = 8'h01;

    typedef enum logic [3:0] {
        CUR_NONE,
        CUR_INC,
        CUR_COL0,
        CUR_ZERO,
        CUR_NEWROW,
        CUR_BS,
        CUR_UP,
        CUR_DOWN,
        CUR_RIGHT,
        CUR_LEFT,
        CUR_HOME
    } cur_op_t;

    typedef enum logic [2:0] {
        OUT_POS,
        OUT_SCAN_POS,
        OUT_CHAR,
        OUT_SPACE,
        OUT_CELL,
        OUT_CLEAR
    } out_sel_t;

    typedef struct packed {
        logic     load_char;
        logic     emit;
        out_sel_t out_sel;
        logic     last;
        logic     wr_cell;
        logic     wr_space;
        cur_op_t  cur_op;
        logic     scroll;
        logic     clr_all;
        logic     scan_clr;
        logic     scan_step;
        logic     clr_params;
        logic     clr_p2;
        logic     digit_p1;
        logic     digit_p2;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic col_wrap;
        logic row_last;
        logic p1_erase;
        logic scan_col_last;
        logic scan_row_last;
    } sts_t;

endpackage

// ===== sv/clt_datapath.sv =====
module clt_datapath #(
    parameter int COLUMNS = clt_pkg::DEF_COLUMNS,
    parameter int ROWS    = clt_pkg::DEF_ROWS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [7:0]          s_char_code,
    input  clt_pkg::cmd_t       cmd,
    output clt_pkg::sts_t       sts,
    input  logic                m_ready,
    output logic                m_valid,
    output logic                m_is_data,
    output logic [7:0]          m_bus_byte,
    output logic                m_last_of_run
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam logic [clt_pkg::COL_W-1:0] COL_MAX = clt_pkg::COL_W'(COLUMNS - 1);
    localparam logic [clt_pkg::COL_W-1:0] COL_END = clt_pkg::COL_W'(COLUMNS);
    localparam logic                      ROW_MAX = 1'(ROWS - 1);
    localparam logic [ADDR_W-1:0]         ROW_OFS = ADDR_W'(COLUMNS);

    logic [clt_pkg::COL_W-1:0] col_reg, col_next;
    logic                      row_reg, row_next;
    logic                      base_reg;
    logic [7:0]                p1_reg, p2_reg;
    logic [7:0]                char_reg;
    logic [clt_pkg::COL_W-1:0] scan_col_reg;
    logic                      scan_row_reg;
    logic [7:0]                mem [CELLS];
    logic [CELLS-1:0]          vld_reg, vld_next;
    logic [7:0]                rd_data_reg;
    logic                      rd_vld_reg;
    logic                      m_valid_reg, m_is_data_reg, m_last_reg;
    logic [7:0]                m_byte_reg;

    logic                      cur_phys, scan_phys, clr_phys;
    logic [ADDR_W-1:0]         wr_addr, rd_addr;
    logic [7:0]                wr_data;
    logic [7:0]                n_val;
    logic [8:0]                csum;
    logic [clt_pkg::COL_W-1:0] col_clamp;
    logic [7:0]                p2_less;
    logic [11:0]               dig_p1, dig_p2;
    logic                      out_data;
    logic [7:0]                out_byte;

    // row rotation: scrolling flips which physical row is on top
    assign cur_phys  = (ROWS == 2) ? (row_reg ^ base_reg) : 1'b0;
    assign scan_phys = (ROWS == 2) ? (scan_row_reg ^ base_reg) : 1'b0;
    assign clr_phys  = (ROWS == 2) ? base_reg : 1'b0;
    assign wr_addr   = (cur_phys ? ROW_OFS : '0) + ADDR_W'(col_reg);
    assign rd_addr   = (scan_phys ? ROW_OFS : '0) + ADDR_W'(scan_col_reg);
    assign wr_data   = cmd.wr_space ? clt_pkg::CHAR_SPACE : char_reg;

    // cursor arithmetic
    assign n_val     = (p1_reg == 8'd0) ? 8'd1 : p1_reg;
    assign csum      = 9'(col_reg) + 9'(n_val);
    assign col_clamp = (col_reg > COL_MAX) ? COL_MAX : col_reg;
    assign p2_less   = p2_reg - 8'd1;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        case (cmd.cur_op)
            clt_pkg::CUR_INC:  col_next = col_reg + 1'b1;
            clt_pkg::CUR_COL0: col_next = '0;
            clt_pkg::CUR_ZERO: begin
                col_next = '0;
                row_next = 1'b0;
            end
            clt_pkg::CUR_NEWROW: begin
                col_next = '0;
                row_next = (row_reg == ROW_MAX) ? row_reg : ~row_reg;
            end
            clt_pkg::CUR_BS: begin
                if (col_reg != '0) begin
                    col_next = col_reg - 1'b1;
                end else if (row_reg) begin
                    col_next = COL_MAX;
                    row_next = 1'b0;
                end
            end
            clt_pkg::CUR_UP: begin
                col_next = col_clamp;
                row_next = 1'b0;
            end
            clt_pkg::CUR_DOWN: begin
                col_next = col_clamp;
                row_next = ROW_MAX;
            end
            clt_pkg::CUR_RIGHT: begin
                col_next = (csum > 9'(COL_MAX)) ? COL_MAX : clt_pkg::COL_W'(csum);
            end
            clt_pkg::CUR_LEFT: begin
                col_next = (9'(n_val) >= 9'(col_reg)) ? '0
                                                      : col_reg - clt_pkg::COL_W'(n_val);
            end
            clt_pkg::CUR_HOME: begin
                row_next = (p1_reg >= 8'd2) ? ROW_MAX : 1'b0;
                if (p2_reg <= 8'd1) begin
                    col_next = '0;
                end else if (p2_less > 8'(COL_MAX)) begin
                    col_next = COL_MAX;
                end else begin
                    col_next = clt_pkg::COL_W'(p2_less);
                end
            end
            default: ;
        endcase
    end

    // decimal parameter accumulation with saturation
    assign dig_p1 = {1'b0, p1_reg, 3'b0} + {3'b0, p1_reg, 1'b0} + 12'(s_char_code[3:0]);
    assign dig_p2 = {1'b0, p2_reg, 3'b0} + {3'b0, p2_reg, 1'b0} + 12'(s_char_code[3:0]);

    // cell valid bits: an invalid cell reads as a space
    always_comb begin
        vld_next = vld_reg;
        if (cmd.clr_all) begin
            vld_next = '0;
        end else if (cmd.scroll) begin
            for (int i = 0; i < CELLS; i++) begin
                if ((i / COLUMNS) == int'(clr_phys)) vld_next[i] = 1'b0;
            end
        end else if (cmd.wr_cell) begin
            vld_next[wr_addr] = 1'b1;
        end
    end

    // output byte selection
    always_comb begin
        out_data = 1'b0;
        out_byte = clt_pkg::CMD_BLANK_ALL;
        case (cmd.out_sel)
            clt_pkg::OUT_POS:      out_byte = {1'b1, row_reg, 6'(col_reg)};
            clt_pkg::OUT_SCAN_POS: out_byte = {1'b1, scan_row_reg, 6'b0};
            clt_pkg::OUT_CHAR: begin
                out_data = 1'b1;
                out_byte = char_reg;
            end
            clt_pkg::OUT_SPACE: begin
                out_data = 1'b1;
                out_byte = clt_pkg::CHAR_SPACE;
            end
            clt_pkg::OUT_CELL: begin
                out_data = 1'b1;
                out_byte = rd_vld_reg ? rd_data_reg : clt_pkg::CHAR_SPACE;
            end
            clt_pkg::OUT_CLEAR: out_byte = clt_pkg::CMD_BLANK_ALL;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= 1'b0;
            base_reg     <= 1'b0;
            p1_reg       <= '0;
            p2_reg       <= '0;
            scan_col_reg <= '0;
            scan_row_reg <= 1'b0;
            vld_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            vld_reg <= vld_next;
            if (cmd.scroll) base_reg <= ~base_reg;
            if (cmd.clr_params) begin
                p1_reg <= '0;
                p2_reg <= '0;
            end else begin
                if (cmd.digit_p1) p1_reg <= (dig_p1 > 12'd255) ? 8'd255 : dig_p1[7:0];
                if (cmd.clr_p2) p2_reg <= '0;
                else if (cmd.digit_p2) p2_reg <= (dig_p2 > 12'd255) ? 8'd255 : dig_p2[7:0];
            end
            if (cmd.scan_clr) begin
                scan_col_reg <= '0;
                scan_row_reg <= 1'b0;
            end else if (cmd.scan_step) begin
                if (scan_col_reg == COL_MAX) begin
                    scan_col_reg <= '0;
                    scan_row_reg <= ~scan_row_reg;
                end else begin
                    scan_col_reg <= scan_col_reg + 1'b1;
                end
            end
            if (cmd.emit) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_char) char_reg <= s_char_code;
        if (cmd.emit) begin
            m_is_data_reg <= out_data;
            m_byte_reg    <= out_byte;
            m_last_reg    <= cmd.last;
        end
    end

    // cell memory, registered read
    always_ff @(posedge aclk) begin
        if (cmd.wr_cell) mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
        rd_vld_reg  <= vld_reg[rd_addr];
    end

    assign sts.out_free      = !m_valid_reg || m_ready;
    assign sts.col_wrap      = (col_reg >= COL_END);
    assign sts.row_last      = (row_reg == ROW_MAX);
    assign sts.p1_erase      = (p1_reg == 8'd2) || (p1_reg == 8'd3);
    assign sts.scan_col_last = (scan_col_reg == COL_MAX);
    assign sts.scan_row_last = (scan_row_reg == ROW_MAX);

    assign m_valid       = m_valid_reg;
    assign m_is_data     = m_is_data_reg;
    assign m_bus_byte    = m_byte_reg;
    assign m_last_of_run = m_last_reg;

endmodule

// ===== sv/clt_ctrl.sv =====
module clt_ctrl #(
    parameter int TAB_SPACES = clt_pkg::DEF_TAB_SPACES
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [7:0]    s_char_code,
    input  clt_pkg::sts_t sts,
    output clt_pkg::cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUT_CHECK,
        ST_PUT_EMIT,
        ST_NL_START,
        ST_NL_POS,
        ST_RS_POS,
        ST_RS_RD,
        ST_RS_DATA,
        ST_BS_POS,
        ST_CLR_EMIT,
        ST_POS_LAST
    } state_t;

    typedef enum logic [1:0] {
        MODE_TEXT,
        MODE_ESC,
        MODE_SEQ
    } mode_t;

    typedef enum logic [1:0] {
        K_PUT,
        K_TAB,
        K_NL,
        K_BS
    } kind_t;

    state_t                     state_reg, state_next;
    mode_t                      mode_reg, mode_next;
    kind_t                      kind_reg, kind_next;
    logic [clt_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic [clt_pkg::TAB_W-1:0]  tab_reg, tab_next;
    logic                       accept;
    logic                       is_digit;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign is_digit = (s_char_code >= clt_pkg::CHAR_ZERO) && (s_char_code <= clt_pkg::CHAR_NINE);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        kind_next  = kind_reg;
        slot_next  = slot_reg;
        tab_next   = tab_reg;
        cmd        = '0;
        cmd.cur_op  = clt_pkg::CUR_NONE;
        cmd.out_sel = clt_pkg::OUT_POS;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load_char = 1'b1;
                    case (mode_reg)
                        MODE_ESC: begin
                            if (s_char_code == clt_pkg::CHAR_LBRACK) begin
                                mode_next      = MODE_SEQ;
                                slot_next      = '0;
                                cmd.clr_params = 1'b1;
                            end else begin
                                mode_next = MODE_TEXT;
                            end
                        end
                        MODE_SEQ: begin
                            if (s_char_code == clt_pkg::CHAR_SEMI) begin
                                if (slot_reg != clt_pkg::SLOT_LAST) begin
                                    slot_next  = slot_reg + 1'b1;
                                    cmd.clr_p2 = (slot_reg == '0);
                                end else begin
                                    mode_next = MODE_TEXT;
                                end
                            end else if (is_digit) begin
                                cmd.digit_p1 = (slot_reg == 4'd0);
                                cmd.digit_p2 = (slot_reg == 4'd1);
                            end else begin
                                mode_next = MODE_TEXT;
                                case (s_char_code)
                                    clt_pkg::CHAR_A: begin
                                        cmd.cur_op = clt_pkg::CUR_UP;
                                        state_next = ST_POS_LAST;
                                    end
                                    clt_pkg::CHAR_B: begin
                                        cmd.cur_op = clt_pkg::CUR_DOWN;
                                        state_next = ST_POS_LAST;
                                    end
                                    clt_pkg::CHAR_C: begin
                                        cmd.cur_op = clt_pkg::CUR_RIGHT;
                                        state_next = ST_POS_LAST;
                                    end
                                    clt_pkg::CHAR_D: begin
                                        cmd.cur_op = clt_pkg::CUR_LEFT;
                                        state_next = ST_POS_LAST;
                                    end
                                    clt_pkg::CHAR_H: begin
                                        cmd.cur_op = clt_pkg::CUR_HOME;
                                        state_next = ST_POS_LAST;
                                    end
                                    clt_pkg::CHAR_J: begin
                                        if (sts.p1_erase) begin
                                            cmd.clr_all = 1'b1;
                                            cmd.cur_op  = clt_pkg::CUR_ZERO;
                                            state_next  = ST_CLR_EMIT;
                                        end
                                    end
                                    default: ;
                                endcase
                            end
                        end
                        default: begin
                            case (s_char_code)
                                clt_pkg::CHAR_ESC: mode_next = MODE_ESC;
                                clt_pkg::CHAR_LF: begin
                                    kind_next  = K_NL;
                                    state_next = ST_NL_START;
                                end
                                clt_pkg::CHAR_CR: begin
                                    cmd.cur_op = clt_pkg::CUR_COL0;
                                    state_next = ST_POS_LAST;
                                end
                                clt_pkg::CHAR_TAB: begin
                                    kind_next  = K_TAB;
                                    tab_next   = clt_pkg::TAB_W'(TAB_SPACES - 1);
                                    state_next = ST_PUT_CHECK;
                                end
                                clt_pkg::CHAR_BS: begin
                                    kind_next  = K_BS;
                                    cmd.cur_op = clt_pkg::CUR_BS;
                                    state_next = ST_BS_POS;
                                end
                                default: begin
                                    kind_next  = K_PUT;
                                    state_next = ST_PUT_CHECK;
                                end
                            endcase
                        end
                    endcase
                end
            end
            // wrap pending: move to the next row first
            ST_PUT_CHECK: begin
                state_next = sts.col_wrap ? ST_NL_START : ST_PUT_EMIT;
            end
            ST_PUT_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.out_sel  = (kind_reg == K_TAB) ? clt_pkg::OUT_SPACE : clt_pkg::OUT_CHAR;
                    cmd.wr_cell  = 1'b1;
                    cmd.wr_space = (kind_reg == K_TAB);
                    cmd.cur_op   = clt_pkg::CUR_INC;
                    if (kind_reg == K_TAB && tab_reg != '0) begin
                        tab_next   = tab_reg - 1'b1;
                        state_next = ST_PUT_CHECK;
                    end else begin
                        cmd.last   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_NL_START: begin
                cmd.cur_op = clt_pkg::CUR_NEWROW;
                if (sts.row_last) begin
                    cmd.scroll   = 1'b1;
                    cmd.scan_clr = 1'b1;
                    state_next   = ST_RS_POS;
                end else begin
                    state_next = ST_NL_POS;
                end
            end
            ST_NL_POS: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.last   = (kind_reg == K_NL);
                    state_next = (kind_reg == K_NL) ? ST_IDLE : ST_PUT_EMIT;
                end
            end
            // full buffer resend
            ST_RS_POS: begin
                if (sts.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.out_sel = clt_pkg::OUT_SCAN_POS;
                    state_next  = ST_RS_RD;
                end
            end
            ST_RS_RD: begin
                state_next = ST_RS_DATA;
            end
            ST_RS_DATA: begin
                if (sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.out_sel   = clt_pkg::OUT_CELL;
                    cmd.scan_step = 1'b1;
                    if (!sts.scan_col_last) begin
                        state_next = ST_RS_RD;
                    end else if (!sts.scan_row_last) begin
                        state_next = ST_RS_POS;
                    end else begin
                        state_next = (kind_reg == K_BS) ? ST_POS_LAST : ST_NL_POS;
                    end
                end
            end
            ST_BS_POS: begin
                if (sts.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.wr_cell  = 1'b1;
                    cmd.wr_space = 1'b1;
                    cmd.scan_clr = 1'b1;
                    state_next   = ST_RS_POS;
                end
            end
            ST_CLR_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.out_sel = clt_pkg::OUT_CLEAR;
                    state_next  = ST_POS_LAST;
                end
            end
            ST_POS_LAST: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_TEXT;
            kind_reg  <= K_PUT;
            slot_reg  <= '0;
            tab_reg   <= '0;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            kind_reg  <= kind_next;
            slot_reg  <= slot_next;
            tab_reg   <= tab_next;
        end
    end

endmodule

// ===== sv/char_lcd_text_terminal.sv =====
// newline with scroll and backspace resend the whole buffer through the single registered
// cell read port; one character is worked on at a time, and the next is taken
// once its last result is registered, or at once if the character gives no result
// reset: synchronous active low, clears cursor, parser and cell valid bits (cells read as
// spaces at once, no clearing pass)
module char_lcd_text_terminal #(
    parameter int COLUMNS    = clt_pkg::DEF_COLUMNS,
    parameter int ROWS       = clt_pkg::DEF_ROWS,
    parameter int TAB_SPACES = clt_pkg::DEF_TAB_SPACES
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_code,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_is_data,
    output logic [7:0] m_bus_byte,
    output logic       m_last_of_run
);

    clt_pkg::cmd_t cmd;
    clt_pkg::sts_t sts;

    // sequencer
    clt_ctrl #(
        .TAB_SPACES (TAB_SPACES)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .sts         (sts),
        .cmd         (cmd)
    );

    // cursor, parameters, cell memory and output register
    clt_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_char_code   (s_char_code),
        .cmd           (cmd),
        .sts           (sts),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_is_data     (m_is_data),
        .m_bus_byte    (m_bus_byte),
        .m_last_of_run (m_last_of_run)
    );

`ifndef ASSERT_OFF
    // never load the output register while it holds an untaken transaction
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> sts.out_free)
        else $error("result emitted into a full output register");

    // the last result of a run hands control back for the next character
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && cmd.last) |=> s_ready)
        else $error("not ready after the last result of a run");

    // a cell write never lands on a pending-wrap column
    a_wr_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_cell |-> !sts.col_wrap)
        else $error("cell write past the last column");
`endif

endmodule
